FILE: rtl/ptas_pkg.sv
// Package for the policy table action sampler: field widths, status and
// command codes, and the descriptor passed from front end to back end.
// No dependencies.
package ptas_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int PROB_W        = FRACTION_BITS + 1;
  localparam int DRAW_W        = FRACTION_BITS;
  localparam int STATE_W       = 4;
  localparam int ACTION_W      = 3;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 8;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRACTION_BITS;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_WRITTEN   = 2'd0,
    STATUS_SAMPLED   = 2'd1,
    STATUS_NO_ACTION = 2'd2
  } status_t;

  // Classified command
  typedef struct packed {
    logic                is_sample;
    logic                in_range;
    logic [STATE_W-1:0]  state_index;
    logic [ACTION_W-1:0] action_index;
    logic [PROB_W-1:0]   probability;
    logic [DRAW_W-1:0]   random_draw;
  } desc_t;

endpackage

FILE: rtl/ptas_front.sv
// Front end: accepts input transactions, saturates the probability,
// range-checks indexes and holds one classified descriptor.
// Depends on ptas_pkg.
module ptas_front #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ptas_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  output logic                               desc_valid,
  input  logic                               desc_ready,
  output ptas_pkg::desc_t                    desc
);
  import ptas_pkg::*;

  logic  desc_vld_r, desc_vld_nxt;
  desc_t desc_r;
  desc_t cls_c;
  logic  accept;
  logic  state_ok;
  logic  action_ok;

  always_comb begin
    cls_c.is_sample    = (in_tuser == CMD_SAMPLE);
    cls_c.state_index  = in_tdata[3:0];
    cls_c.action_index = in_tdata[6:4];
    cls_c.random_draw  = in_tdata[39:24];
    // saturate anything above one
    if (in_tdata[23:7] > PROB_ONE) begin
      cls_c.probability = PROB_ONE;
    end else begin
      cls_c.probability = in_tdata[23:7];
    end
    state_ok  = (32'(cls_c.state_index) < NUM_STATES);
    action_ok = (32'(cls_c.action_index) < NUM_ACTIONS);
    cls_c.in_range = cls_c.is_sample ? state_ok : (state_ok && action_ok);
  end

  assign in_tready  = !desc_vld_r || desc_ready;
  assign accept     = in_tvalid && in_tready;
  assign desc_valid = desc_vld_r;
  assign desc       = desc_r;

  always_comb begin
    desc_vld_nxt = desc_vld_r;
    if (accept) begin
      desc_vld_nxt = 1'b1;
    end else if (desc_ready) begin
      desc_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_vld_r <= 1'b0;
    end else begin
      desc_vld_r <= desc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= cls_c;
    end
  end

endmodule

FILE: rtl/ptas_cmd_fifo.sv
// Two-entry descriptor queue between front end and back end.
// Depends on ptas_pkg.
module ptas_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ptas_pkg::desc_t push_desc,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ptas_pkg::desc_t pop_desc
);
  import ptas_pkg::*;

  desc_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_desc   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: rtl/ptas_back.sv
// Back end: probability table memory, inverse-CDF walk sequencer and
// result register. Depends on ptas_pkg.
module ptas_back #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  ptas_pkg::desc_t                 cmd,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptas_pkg::ACTION_W-1:0]   res_action,
  output ptas_pkg::status_t               res_status
);
  import ptas_pkg::*;

  localparam int DEPTH     = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACT_IDX_W = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int CNT_W     = $clog2(NUM_ACTIONS + 1);
  localparam int SUM_W     = PROB_W + $clog2(NUM_ACTIONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SAMPLE = 3'b010,
    ST_OUT    = 3'b100
  } bst_t;

  bst_t                  state_r, state_nxt;
  logic [STATE_W-1:0]    row_r, row_nxt;
  logic [DRAW_W-1:0]     draw_r, draw_nxt;
  logic [CNT_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ACT_IDX_W-1:0]  cons_ptr_r, cons_ptr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]      running_r, running_nxt;
  logic [ACTION_W-1:0]   act_r, act_nxt;
  status_t               status_r, status_nxt;

  logic [PROB_W-1:0]     mem_r [DEPTH];
  logic [DEPTH-1:0]      ent_set_r;
  logic [PROB_W-1:0]     rd_data_r;
  logic                  rd_set_r;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  mem_we;
  logic [SUM_W-1:0]      sum_c;

  assign wr_addr = ADDR_W'(32'(cmd.state_index) * NUM_ACTIONS + 32'(cmd.action_index));
  assign rd_addr = ADDR_W'(32'(row_r) * NUM_ACTIONS + 32'(rd_ptr_r));
  // entries never written read as zero
  assign sum_c   = running_r + (rd_set_r ? SUM_W'(rd_data_r) : SUM_W'(0));

  assign cmd_ready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign res_action = act_r;
  assign res_status = status_r;

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    draw_nxt     = draw_r;
    rd_ptr_nxt   = rd_ptr_r;
    cons_ptr_nxt = cons_ptr_r;
    rd_vld_nxt   = rd_vld_r;
    running_nxt  = running_r;
    act_nxt      = act_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          act_nxt = '0;
          if (!cmd.is_sample) begin
            mem_we     = cmd.in_range;
            status_nxt = STATUS_WRITTEN;
            state_nxt  = ST_OUT;
          end else if (cmd.in_range) begin
            row_nxt      = cmd.state_index;
            draw_nxt     = cmd.random_draw;
            rd_ptr_nxt   = '0;
            cons_ptr_nxt = '0;
            rd_vld_nxt   = 1'b0;
            running_nxt  = '0;
            state_nxt    = ST_SAMPLE;
          end else begin
            status_nxt = STATUS_NO_ACTION;
            state_nxt  = ST_OUT;
          end
        end
      end
      ST_SAMPLE: begin
        // issue one read per cycle, consume the previous one
        if (32'(rd_ptr_r) < NUM_ACTIONS) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          if (SUM_W'(draw_r) <= sum_c) begin
            act_nxt    = ACTION_W'(cons_ptr_r);
            status_nxt = STATUS_SAMPLED;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_OUT;
          end else if (cons_ptr_r == ACT_IDX_W'(NUM_ACTIONS - 1)) begin
            act_nxt    = '0;
            status_nxt = STATUS_NO_ACTION;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_OUT;
          end else begin
            running_nxt  = sum_c;
            cons_ptr_nxt = cons_ptr_r + ACT_IDX_W'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_vld_r   <= 1'b0;
      ent_set_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (mem_we) begin
        ent_set_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    draw_r     <= draw_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    cons_ptr_r <= cons_ptr_nxt;
    running_r  <= running_nxt;
    act_r      <= act_nxt;
    status_r   <= status_nxt;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= cmd.probability;
    end
    rd_data_r <= mem_r[rd_addr];
    rd_set_r  <= ent_set_r[rd_addr] && !(mem_we && (wr_addr == rd_addr));
  end

endmodule

FILE: rtl/policy_table_action_sampler_unit.sv
// Top level of the policy table action sampler.
// Depends on ptas_pkg, ptas_front, ptas_cmd_fifo and ptas_back.
//
// Usage:
//   Input channel (in_*): one transaction per command. in_tuser selects the
//   command: write one table entry or sample an action. A write stores a
//   probability (Q1.16, saturated to one) at a state and action; a sample
//   walks the state's row in action order and returns the first action whose
//   running sum reaches the Q0.16 draw.
//   Output channel (out_*): exactly one result transaction per command, in
//   command order: the chosen action and a status (written, sampled, or no
//   action: none reached the draw or the state index is out of range).
//   Sample duration is set by the row walk, which reads one table entry per
//   cycle from the single read port of the table memory.
//   Back end: one command in flight; it takes no new command until the
//   result of the last one has been accepted on the output channel.
//   Reset: synchronous, active low; all table entries read as zero after
//   reset through per-entry valid flags, so no clearing pass is needed.
//   Stall: while out_tready is low the result is held; the front register
//   and the two-entry command queue keep accepting until full.
module policy_table_action_sampler_unit #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [3:0] state_index, [6:4] action_index, [23:7] probability,
  // [39:24] random_draw
  input  logic [ptas_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] command
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] chosen_action, [7:3] zero
  output logic [ptas_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [ptas_pkg::STATUS_W-1:0]     out_tuser
);
  import ptas_pkg::*;

  logic                front_vld;
  logic                front_rdy;
  desc_t               front_desc;
  logic                q_vld;
  logic                q_rdy;
  desc_t               q_desc;
  logic [ACTION_W-1:0] res_action;
  status_t             res_status;

  // classify and hold the incoming command
  ptas_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .desc_valid (front_vld),
    .desc_ready (front_rdy),
    .desc       (front_desc)
  );

  // decouple front end from the table walk
  ptas_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_vld),
    .push_ready (front_rdy),
    .push_desc  (front_desc),
    .pop_valid  (q_vld),
    .pop_ready  (q_rdy),
    .pop_desc   (q_desc)
  );

  // execute writes and samples against the table
  ptas_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_vld),
    .cmd_ready  (q_rdy),
    .cmd        (q_desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_action (res_action),
    .res_status (res_status)
  );

  assign out_tdata = {(OUT_DATA_W - ACTION_W)'(0), res_action};
  assign out_tuser = res_status;

endmodule

FILE: tb/tb_policy_table_action_sampler_unit.sv
// Self-checking testbench for policy_table_action_sampler_unit: writes and
// samples of the probability table, scored against a mirror of the table.
// Depends on ptas_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_policy_table_action_sampler_unit;
  import ptas_pkg::*;

  localparam int NUM_STATES   = 16;
  localparam int NUM_ACTIONS  = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_DIRECTED = 24;
  localparam logic [DRAW_W-1:0] DRAW_MAX = '1;
  localparam logic [PROB_W-1:0] PROB_MAX = '1;

  // One result as seen on the output channel
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    status_t             status;
  } outcome_t;

  // One row of the directed stimulus table; typed rows carry their own
  // expected result, the others are scored by the mirror
  typedef struct packed {
    logic                cmd;
    logic [STATE_W-1:0]  state_idx;
    logic [ACTION_W-1:0] action_idx;
    logic [PROB_W-1:0]   prob;
    logic [DRAW_W-1:0]   draw;
    logic                typed;
    logic [ACTION_W-1:0] exp_action;
    status_t             exp_status;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // empty table right after reset: a zero draw still picks action zero
    '{CMD_SAMPLE, 4'd0,  3'd0, 17'd0,      16'd0,     1'b1, 3'd0, STATUS_SAMPLED},
    '{CMD_SAMPLE, 4'd5,  3'd0, 17'd0,      16'd1,     1'b1, 3'd0, STATUS_NO_ACTION},
    '{CMD_SAMPLE, 4'd15, 3'd7, PROB_MAX,   DRAW_MAX,  1'b1, 3'd0, STATUS_NO_ACTION},
    // first and last action of the first row, zero and one
    '{CMD_WRITE,  4'd0,  3'd0, 17'd0,      16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_WRITE,  4'd0,  3'd7, PROB_ONE,   16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd0,  3'd0, 17'd0,      DRAW_MAX,  1'b0, 3'd0, STATUS_WRITTEN},
    // value above one saturates on the last row
    '{CMD_WRITE,  4'd15, 3'd3, PROB_MAX,   16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd15, 3'd0, 17'd0,      DRAW_MAX,  1'b0, 3'd0, STATUS_WRITTEN},
    '{CMD_WRITE,  4'd15, 3'd0, 17'd1,      16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd15, 3'd0, 17'd0,      16'd1,     1'b0, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd15, 3'd0, 17'd0,      16'd2,     1'b0, 3'd0, STATUS_WRITTEN},
    // sparse row with gaps between nonzero entries
    '{CMD_WRITE,  4'd3,  3'd1, 17'd16384,  16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_WRITE,  4'd3,  3'd4, 17'd16384,  16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_WRITE,  4'd3,  3'd6, 17'd32768,  16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd3,  3'd0, 17'd0,      16'd16384, 1'b0, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd3,  3'd0, 17'd0,      16'd16385, 1'b0, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd3,  3'd0, 17'd0,      DRAW_MAX,  1'b0, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd3,  3'd0, 17'd0,      16'd0,     1'b1, 3'd0, STATUS_SAMPLED},
    // row sum one short of one, then a row that never reaches the draw
    '{CMD_WRITE,  4'd3,  3'd6, 17'd32767,  16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd3,  3'd0, 17'd0,      DRAW_MAX,  1'b0, 3'd0, STATUS_WRITTEN},
    '{CMD_WRITE,  4'd3,  3'd6, 17'd0,      16'd0,     1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd3,  3'd0, 17'd0,      16'd32769, 1'b0, 3'd0, STATUS_WRITTEN},
    // unused fields carry extreme values and must be ignored
    '{CMD_WRITE,  4'd9,  3'd2, 17'h10001,  DRAW_MAX,  1'b1, 3'd0, STATUS_WRITTEN},
    '{CMD_SAMPLE, 4'd9,  3'd7, PROB_MAX,   DRAW_MAX,  1'b0, 3'd0, STATUS_WRITTEN}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Mirror of the probability table and the results still owed by the block
  logic [PROB_W-1:0] mirror_table [NUM_STATES][NUM_ACTIONS];
  outcome_t          pending_outcomes [$];
  outcome_t          head_outcome;

  int error_count = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int send_idle_pct = 17;
  int recv_idle_pct = 45;

  policy_table_action_sampler_unit #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Update the mirror on a write; walk the mirrored row on a sample and
  // return the first action whose running sum reaches the draw
  function automatic outcome_t predict_outcome(input logic cmd,
                                               input logic [STATE_W-1:0] st,
                                               input logic [ACTION_W-1:0] act,
                                               input logic [PROB_W-1:0] prob,
                                               input logic [DRAW_W-1:0] draw);
    outcome_t    res;
    logic [19:0] running_sum;
    res.action  = '0;
    running_sum = '0;
    if (cmd == CMD_WRITE) begin
      res.status = STATUS_WRITTEN;
      if (int'(st) < NUM_STATES && int'(act) < NUM_ACTIONS)
        mirror_table[st][act] = (prob > PROB_ONE) ? PROB_ONE : prob;
    end else begin
      res.status = STATUS_NO_ACTION;
      if (int'(st) < NUM_STATES) begin
        for (int a = 0; a < NUM_ACTIONS; a++) begin
          running_sum = running_sum + 20'(mirror_table[st][a]);
          if (res.status == STATUS_NO_ACTION && 20'(draw) <= running_sum) begin
            res.action = ACTION_W'(a);
            res.status = STATUS_SAMPLED;
          end
        end
      end
    end
    return res;
  endfunction

  // Pick a probability: mostly small shares so a row adds up near one,
  // with zeros, exact ones, saturating values and raw 17-bit noise mixed in
  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PROB_ONE;
      2:       return PROB_W'($urandom_range(0, 131071));
      3:       return PROB_W'($urandom_range(65537, 131071));
      default: return PROB_W'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic logic [DRAW_W-1:0] pick_draw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DRAW_MAX;
      default: return DRAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Drive one command transaction; call at a falling edge, returns at one.
  // Record the expected result at the accepting edge.
  task automatic drive_command(input logic cmd, input logic [STATE_W-1:0] st,
                               input logic [ACTION_W-1:0] act,
                               input logic [PROB_W-1:0] prob,
                               input logic [DRAW_W-1:0] draw,
                               input logic typed, input outcome_t typed_outcome);
    outcome_t predicted;
    // idle pattern: sender light / receiver heavy, then swapped, then none
    case (items_sent * 3 / (RANDOM_ITEMS + NUM_DIRECTED))
      0:       begin send_idle_pct = 17; recv_idle_pct = 45; end
      1:       begin send_idle_pct = 45; recv_idle_pct = 17; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {draw, prob, act, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_outcome(cmd, st, act, prob, draw);
    pending_outcomes.insert(pending_outcomes.size(),
                            typed ? typed_outcome : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // Receiver: drop tready at random while the current phase asks for it
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Score every result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("unexpected result action=%0d status=%0d",
                                out_tdata, out_tuser));
      end else begin
        head_outcome = pending_outcomes.pop_front();
        if (out_tdata !== {{(OUT_DATA_W-ACTION_W){1'b0}}, head_outcome.action})
          note_mismatch($sformatf("chosen_action expected %0d got %0d (tdata %h)",
                                  head_outcome.action, out_tdata[ACTION_W-1:0],
                                  out_tdata));
        if (out_tuser !== head_outcome.status)
          note_mismatch($sformatf("status expected %0d got %0d",
                                  head_outcome.status, out_tuser));
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t           row;
    outcome_t            row_outcome;
    logic [STATE_W-1:0]  st;
    int                  n_writes;
    int                  n_samples;

    for (int s = 0; s < NUM_STATES; s++)
      for (int a = 0; a < NUM_ACTIONS; a++)
        mirror_table[s][a] = '0;

    // hold reset low, then release it on a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: extremes, both commands, saturation, zero draw,
    // rows that never reach the draw
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      row_outcome.action = row.exp_action;
      row_outcome.status = row.exp_status;
      drive_command(row.cmd, row.state_idx, row.action_idx, row.prob, row.draw,
                    row.typed, row_outcome);
    end

    // random part: mostly episodes that fill part of one row and then
    // sample it; the rest is unstructured noise over all field bits
    row_outcome = '0;
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        st        = STATE_W'($urandom_range(0, NUM_STATES - 1));
        n_writes  = $urandom_range(1, NUM_ACTIONS);
        n_samples = $urandom_range(1, 6);
        repeat (n_writes)
          drive_command(CMD_WRITE, st, ACTION_W'($urandom_range(0, NUM_ACTIONS - 1)),
                        pick_prob(), DRAW_W'($urandom_range(0, 65535)), 1'b0,
                        row_outcome);
        repeat (n_samples)
          drive_command(CMD_SAMPLE, st, ACTION_W'($urandom_range(0, 7)),
                        PROB_W'($urandom_range(0, 131071)), pick_draw(), 1'b0,
                        row_outcome);
      end else begin
        drive_command(1'($urandom_range(0, 1)), STATE_W'($urandom_range(0, 15)),
                      ACTION_W'($urandom_range(0, 7)),
                      PROB_W'($urandom_range(0, 131071)),
                      DRAW_W'($urandom_range(0, 65535)), 1'b0, row_outcome);
      end
    end
    in_tvalid <= 1'b0;

    // drain: wait for every owed result, then keep watching for strays
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
